/* hdl/mtq_pkg.sv */
`default_nettype none

package mtq_pkg;

  // operation codes carried in func
  localparam logic [2:0] FN_ENQ   = 3'd0;
  localparam logic [2:0] FN_DEQ   = 3'd1;
  localparam logic [2:0] FN_MIN   = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* hdl/min_tracking_queue.sv */
`default_nettype none

// Channel   Handshake                   Word
// --------  --------------------------  ---------------------------------
// input     in_valid / in_ready         func, value, position
// output    out_valid / out_ready       status, data, occupancy
//
// Enqueue and find minimum scan every stored entry; dequeue and read fetch
// one entry; refused operations, clear and unused codes skip the scan. The
// entry memory has a single read port, which the scan walks one entry per
// cycle through one shared equal / signed-less comparator.
// Reset (rst, synchronous) empties the queue; the memory is not cleared.
// A result waiting on out_ready holds the sequencer in its final state.
module min_tracking_queue #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire        [2:0]                      func,
  input  wire signed [mtq_pkg::DATA_W-1:0]      value,
  input  wire        [mtq_pkg::POS_W-1:0]       position,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic       [2:0]                      status,
  output logic signed [mtq_pkg::DATA_W-1:0]     data,
  output logic       [$clog2(CAPACITY+1)-1:0]   occupancy
);
  import mtq_pkg::*;

  localparam int unsigned PW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PCW = (CW > POS_W) ? CW : POS_W;

  // slot of an offset from the front, wrapped at CAPACITY
  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) sum = sum - (CW+1)'(CAPACITY);
    return sum[PW-1:0];
  endfunction

  state_t             state, state_next;
  logic [2:0]         op, op_next;
  logic [DATA_W-1:0]  val, val_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      lim, lim_next;
  logic               rvalid, rvalid_next;
  logic [DATA_W-1:0]  acc, acc_next;
  logic               found, found_next;
  logic [PW-1:0]      front, front_next;
  logic [CW-1:0]      count, count_next;
  logic [2:0]         res_status, res_status_next;
  logic [DATA_W-1:0]  res_data, res_data_next;
  logic               out_valid_next;
  logic [2:0]         status_next;
  logic [DATA_W-1:0]  data_next;
  logic [CW-1:0]      occupancy_next;

  logic [DATA_W-1:0]  mem [CAPACITY];
  logic [DATA_W-1:0]  rdata;
  logic [PW-1:0]      raddr, waddr;
  logic               mem_we;
  logic               is_eq, is_lt;

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= val;
    rdata <= mem[raddr];
  end

  assign raddr = slot(front, idx);
  assign waddr = slot(front, count);

  // shared comparator
  assign is_eq = (rdata == val);
  assign is_lt = ($signed(rdata) < $signed(acc));

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rvalid    <= 1'b0;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rvalid    <= rvalid_next;
      front     <= front_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    op         <= op_next;
    val        <= val_next;
    idx        <= idx_next;
    lim        <= lim_next;
    acc        <= acc_next;
    found      <= found_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    status     <= status_next;
    data       <= data_next;
    occupancy  <= occupancy_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    op_next         = op;
    val_next        = val;
    idx_next        = idx;
    lim_next        = lim;
    rvalid_next     = 1'b0;
    acc_next        = acc;
    found_next      = found;
    front_next      = front;
    count_next      = count;
    res_status_next = res_status;
    res_data_next   = res_data;
    status_next     = status;
    data_next       = data;
    occupancy_next  = occupancy;
    out_valid_next  = out_valid && !out_ready;
    mem_we          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next         = func;
          val_next        = value;
          idx_next        = '0;
          lim_next        = count;
          found_next      = 1'b0;
          res_status_next = ST_OK;
          res_data_next   = '0;
          state_next      = S_DONE;
          unique case (func)
            FN_ENQ: begin
              if (count == CW'(CAPACITY)) res_status_next = ST_FULL;
              else state_next = S_SCAN;
            end
            FN_DEQ: begin
              if (count == '0) res_status_next = ST_EMPTY;
              else begin
                lim_next   = CW'(1);
                state_next = S_SCAN;
              end
            end
            FN_MIN: begin
              if (count == '0) res_status_next = ST_EMPTY;
              else state_next = S_SCAN;
            end
            FN_READ: begin
              if (count == '0) res_status_next = ST_EMPTY;
              else if (PCW'(position) >= PCW'(count)) res_status_next = ST_RANGE;
              else begin
                idx_next   = CW'(position);
                lim_next   = CW'(position) + CW'(1);
                state_next = S_SCAN;
              end
            end
            FN_CLEAR: begin
              count_next = '0;
              front_next = '0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (idx != lim) begin
          rvalid_next = 1'b1;
          idx_next    = idx + CW'(1);
        end
        // fold in the word read last cycle
        if (rvalid) begin
          priority case (op)
            FN_ENQ: if (is_eq) found_next = 1'b1;
            FN_MIN: begin
              if (!found || is_lt) begin
                acc_next   = rdata;
                found_next = 1'b1;
              end
            end
            default: acc_next = rdata;
          endcase
        end
        // scan drained: commit
        if (idx == lim && !rvalid) begin
          state_next = S_DONE;
          priority case (op)
            FN_ENQ: begin
              if (found) res_status_next = ST_DUP;
              else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            FN_DEQ: begin
              res_data_next = acc;
              front_next    = slot(front, CW'(1));
              count_next    = count - CW'(1);
            end
            default: res_data_next = acc;
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          data_next      = res_data;
          occupancy_next = count;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == CW'(CAPACITY))
    else $error("full status with room left");

  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && data == '0)
    else $error("empty status on non-empty queue");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

endmodule

`default_nettype wire

/* tb/mtq_result_checker.sv */
`default_nettype none

// Watches both channels of min_tracking_queue. Every accepted input word runs
// through a mirror of the queue, and the result it should produce is queued.
// Every accepted output word is compared against the oldest queued result.
module mtq_result_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  input  wire                                  in_ready,
  input  wire        [2:0]                     func,
  input  wire signed [mtq_pkg::DATA_W-1:0]     value,
  input  wire        [mtq_pkg::POS_W-1:0]      position,
  input  wire                                  out_valid,
  input  wire                                  out_ready,
  input  wire        [2:0]                     status,
  input  wire signed [mtq_pkg::DATA_W-1:0]     data,
  input  wire        [$clog2(CAPACITY+1)-1:0]  occupancy,
  output int                                   failures,
  output int                                   owed_count
);

  import mtq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [2:0]                     status;
    logic signed [DATA_W-1:0]       data;
    logic [$clog2(CAPACITY+1)-1:0]  occupancy;
  } op_result_t;

  // mirror of the queue contents
  logic signed [DATA_W-1:0] mirror_store [CAPACITY];
  int                       mirror_head;
  int                       mirror_held;

  op_result_t owed_results [$];
  op_result_t want;
  int         miss_tally;

  initial begin
    mirror_head = 0;
    mirror_held = 0;
    miss_tally  = 0;
  end

  function automatic int slot_of(input int offset);
    return (mirror_head + offset) % CAPACITY;
  endfunction

  // apply one operation to the mirror and return the word it should produce
  function automatic op_result_t apply_op(input logic [2:0] op,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [POS_W-1:0] pos);
    op_result_t               r;
    logic                     seen;
    logic signed [DATA_W-1:0] lo;
    r        = '0;
    r.status = ST_OK;
    seen     = 1'b0;
    case (op)
      FN_ENQ: begin
        // full is checked ahead of the duplicate test
        if (mirror_held == CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = 0; i < mirror_held; i++)
            if (mirror_store[slot_of(i)] == val) seen = 1'b1;
          if (seen) begin
            r.status = ST_DUP;
          end else begin
            mirror_store[slot_of(mirror_held)] = val;
            mirror_held++;
          end
        end
      end
      FN_DEQ: begin
        if (mirror_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data      = mirror_store[mirror_head];
          mirror_head = slot_of(1);
          mirror_held--;
        end
      end
      FN_MIN: begin
        if (mirror_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = mirror_store[mirror_head];
          for (int i = 1; i < mirror_held; i++)
            if (mirror_store[slot_of(i)] < lo) lo = mirror_store[slot_of(i)];
          r.data = lo;
        end
      end
      FN_READ: begin
        if (mirror_held == 0) r.status = ST_EMPTY;
        else if (int'(pos) >= mirror_held) r.status = ST_RANGE;
        else r.data = mirror_store[slot_of(int'(pos))];
      end
      FN_CLEAR: begin
        mirror_held = 0;
        mirror_head = 0;
      end
      default: ;  // spare codes change nothing
    endcase
    r.occupancy = CW'(mirror_held);
    return r;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk) begin
    if (rst) begin
      mirror_head = 0;
      mirror_held = 0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready)
        owed_results.insert(owed_results.size(), apply_op(func, value, position));
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("output word with no operation outstanding");
          miss_tally++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            miss_tally++;
          end
          if (data !== want.data) begin
            $error("data mismatch: expected %0d, actual %0d", want.data, data);
            miss_tally++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d",
                   want.occupancy, occupancy);
            miss_tally++;
          end
        end
      end
    end
    failures   <= miss_tally;
    owed_count <= owed_results.size();
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;

  import mtq_pkg::*;

  localparam int unsigned CAPACITY    = 32;
  localparam int          ITEMS       = 650;
  localparam int          CALM_TAIL   = 80;
  localparam int          LONG_HOLD   = 200;
  localparam int          STALL_LIMIT = 2000;

  // func codes the block treats as no-ops
  localparam logic [2:0] FN_SPARE_5 = 3'd5;
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [2:0]                       func;
  logic signed [DATA_W-1:0]         value;
  logic [POS_W-1:0]                 position;
  logic                             out_valid;
  logic                             out_ready;
  logic [2:0]                       status;
  logic signed [DATA_W-1:0]         data;
  logic [$clog2(CAPACITY+1)-1:0]    occupancy;
  int                               failures;
  int                               owed_count;

  // stimulus control shared between the sender and the receiver
  int          n_items;
  bit          calm;
  bit          long_hold_req;
  bit          hold_done;
  int          rx_stall_level;
  int          tx_gap_odds;
  logic [31:0] recent [8];
  int          recent_wr;

  min_tracking_queue #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .occupancy (occupancy)
  );

  mtq_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data       (data),
    .occupancy  (occupancy),
    .failures   (failures),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // drop valid; the argument n sets the length of the gap
  task automatic rest_input(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // offer one word and hold it until accepted, then maybe leave a gap
  task automatic offer(input logic [2:0] op, input logic [31:0] val,
                       input logic [POS_W-1:0] pos);
    @(negedge clk);
    in_valid = 1'b1;
    func     = op;
    value    = val;
    position = pos;
    if (op == FN_ENQ) begin
      recent[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 8;
    end
    n_items++;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 99) < tx_gap_odds)
      rest_input($urandom_range(1, 13));
  endtask

  // small values and recently enqueued ones make duplicates and min ties likely
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return recent[$urandom_range(0, 7)];
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      3, 4:    return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 31));
    return POS_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [2:0] pick_spare();
    case ($urandom_range(0, 2))
      0:       return FN_SPARE_5;
      1:       return FN_SPARE_6;
      default: return FN_SPARE_7;
    endcase
  endfunction

  // operation mix per segment kind
  function automatic logic [2:0] pick_op(input seg_kind_t kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      SEG_FILL: begin
        if (roll < 70) return FN_ENQ;
        if (roll < 78) return FN_MIN;
        if (roll < 88) return FN_READ;
        if (roll < 96) return FN_DEQ;
        return pick_spare();
      end
      SEG_DRAIN: begin
        if (roll < 55) return FN_DEQ;
        if (roll < 70) return FN_MIN;
        if (roll < 85) return FN_READ;
        if (roll < 93) return FN_ENQ;
        if (roll < 96) return FN_CLEAR;
        return pick_spare();
      end
      default: begin
        if (roll < 35) return FN_ENQ;
        if (roll < 55) return FN_DEQ;
        if (roll < 70) return FN_MIN;
        if (roll < 92) return FN_READ;
        if (roll < 95) return FN_CLEAR;
        return pick_spare();
      end
    endcase
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready  = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 15) < rx_stall_level) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // watchdog: too long without any word moving ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    seg_kind_t kind;
    int        seg_len;
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = FN_ENQ;
    value          = '0;
    position       = '0;
    n_items        = 0;
    calm           = 1'b0;
    long_hold_req  = 1'b0;
    hold_done      = 1'b0;
    rx_stall_level = 3;
    tx_gap_odds    = 20;
    recent_wr      = 0;
    for (int i = 0; i < 8; i++) recent[i] = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // empty queue refusals
    offer(FN_DEQ, $urandom, '0);
    offer(FN_MIN, $urandom, '0);
    offer(FN_READ, $urandom, '0);
    // value extremes, duplicate, min and reads in and out of range
    offer(FN_ENQ, 32'h8000_0000, '1);
    offer(FN_ENQ, 32'h7fff_ffff, '0);
    offer(FN_ENQ, 32'h0000_0000, '0);
    offer(FN_ENQ, 32'hffff_ffff, '0);
    offer(FN_ENQ, 32'h0000_0000, '0);
    offer(FN_MIN, $urandom, '0);
    offer(FN_READ, $urandom, 5'd3);
    offer(FN_READ, $urandom, 5'd4);
    offer(FN_READ, $urandom, '1);
    offer(FN_DEQ, $urandom, '0);
    offer(FN_MIN, $urandom, '0);
    offer(FN_READ, $urandom, '0);
    // spare codes with every payload bit set
    offer(FN_SPARE_5, '1, '1);
    offer(FN_SPARE_6, '1, '1);
    offer(FN_SPARE_7, '1, '1);
    offer(FN_CLEAR, $urandom, '0);
    offer(FN_DEQ, $urandom, '0);

    // fill to capacity, then enqueue a new and a stored value while full
    for (int k = 0; k < CAPACITY; k++)
      offer(FN_ENQ, 32'(k * 977) - 32'd15000, '0);
    offer(FN_ENQ, 32'h1234_5678, '0);
    offer(FN_ENQ, recent[$urandom_range(0, 7)], '0);
    offer(FN_READ, $urandom, '1);
    offer(FN_MIN, $urandom, '0);
    offer(FN_DEQ, $urandom, '0);

    // let everything drain before the random part
    rest_input(1);
    wait (owed_count == 0);

    while (n_items < ITEMS) begin
      kind           = seg_kind_t'($urandom_range(0, 2));
      seg_len        = $urandom_range(10, 60);
      rx_stall_level = $urandom_range(0, 6);
      tx_gap_odds    = 10 * $urandom_range(0, 3);
      for (int k = 0; k < seg_len && n_items < ITEMS; k++) begin
        calm = (n_items >= ITEMS - CALM_TAIL);
        // once, midway: receiver holds off while words keep coming
        if (!hold_done && n_items >= ITEMS / 2) begin
          long_hold_req = 1'b1;
          hold_done     = 1'b1;
        end
        offer(pick_op(kind), pick_value(), pick_pos());
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        rest_input(1);
        wait (owed_count == 0);
      end
    end

    rest_input(1);
    wait (owed_count == 0);
    repeat (50) @(posedge clk);
    if (failures == 0 && owed_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
